[src/hbd_pkg.sv]
// package: shared constants and types of the halfband decimator
package hbd_pkg;
  localparam int unsigned MaxTaps   = 32;
  localparam int unsigned NumBanks  = 4;
  localparam int unsigned NumCoeffs = NumBanks * 4;
  localparam int unsigned TapW      = 6;
  localparam int unsigned SampW     = 16;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned AccW      = 40;

  localparam logic [IdxW-1:0] RegTapCount = 3'd0;
  localparam logic [IdxW-1:0] RegBank0    = 3'd1;
  localparam logic [IdxW-1:0] RegBank1    = 3'd2;
  localparam logic [IdxW-1:0] RegBank2    = 3'd3;
  localparam logic [IdxW-1:0] RegBank3    = 3'd4;

  typedef logic signed [SampW-1:0] samp_t;
  typedef logic signed [AccW-1:0]  acc_t;

  typedef struct packed {
    samp_t i;
    samp_t q;
  } iq_t;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StOut
  } state_e;
endpackage

[src/hbd_stream_if.sv]
// interface: valid/ready channel carrying one complex word
interface hbd_stream_if;
  logic               valid;
  logic               ready;
  hbd_pkg::samp_t     data_i;
  hbd_pkg::samp_t     data_q;
  modport source (output valid, output data_i, output data_q, input ready);
  modport sink   (input valid, input data_i, input data_q, output ready);
endinterface

[src/hbd_cell.sv]
// module: one delay line cell holding even and odd complex samples
module hbd_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_even_i,
  input  logic          load_odd_i,
  input  logic          rot_i,
  input  hbd_pkg::iq_t  even_in_i,
  input  hbd_pkg::iq_t  odd_in_i,
  input  hbd_pkg::iq_t  odd_new_i,
  output hbd_pkg::iq_t  even_o,
  output hbd_pkg::iq_t  odd_o
);
  hbd_pkg::iq_t even_q, odd_q;

  // shift_even moves even and odd one place down together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_q <= '0;
      odd_q  <= '0;
    end else if (shift_even_i) begin
      even_q <= even_in_i;
      odd_q  <= odd_in_i;
    end else if (load_odd_i) begin
      odd_q <= odd_new_i;
    end else if (rot_i) begin
      even_q <= even_in_i;
      odd_q  <= odd_in_i;
    end
  end

  assign even_o = even_q;
  assign odd_o  = odd_q;
endmodule

[src/hbd_mac.sv]
// module: multiply-accumulate unit fed one tap pair per cycle while en_i is high
module hbd_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 en_i,
  input  logic signed [15:0]   coeff_i,
  input  hbd_pkg::samp_t       a_i,
  input  hbd_pkg::samp_t       b_i,
  output hbd_pkg::acc_t        acc_o
);
  hbd_pkg::acc_t acc_q;
  logic signed [16:0] sum;
  logic signed [33:0] prod;

  assign sum  = 17'(a_i) + 17'(b_i);
  assign prod = 34'(coeff_i) * 34'(sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clear_i) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_q + hbd_pkg::AccW'(prod);
    end
  end

  assign acc_o = acc_q;
endmodule

[src/halfband_decimator_q15_iq_core.sv]
// top level: chain-of-cells halfband 2:1 decimator for complex Q15 words
// An even word is taken in and gives no output. An odd word starts a pass in
// which the cell chain rotates once around its 32 cells, one cell per cycle, while a
// pair of multiply-accumulate units (I and Q) adds one coefficient term each cycle when
// the right cells pass the chain head; after the pass the sum is rounded into the output
// register, which lets the next even word enter while a result waits. Delay lines reset
// to zero, no clearing pass.
module halfband_decimator_q15_iq_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hbd_stream_if.sink                        in_s,
  hbd_stream_if.source                      out_s,
  input  logic                              cfg_we_i,
  input  logic [hbd_pkg::IdxW-1:0]          cfg_idx_i,
  input  logic [hbd_pkg::CfgW-1:0]          cfg_data_i
);
  localparam int unsigned N = hbd_pkg::MaxTaps;
  localparam int unsigned CntW = $clog2(N);

  logic [hbd_pkg::TapW-1:0] tap_q;
  logic [hbd_pkg::CfgW-1:0] bank_q [hbd_pkg::NumBanks];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= hbd_pkg::TapW'(16);
      for (int b = 0; b < hbd_pkg::NumBanks; b++) bank_q[b] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hbd_pkg::RegTapCount: tap_q <= cfg_data_i[hbd_pkg::TapW-1:0];
        hbd_pkg::RegBank0:    bank_q[0] <= cfg_data_i;
        hbd_pkg::RegBank1:    bank_q[1] <= cfg_data_i;
        hbd_pkg::RegBank2:    bank_q[2] <= cfg_data_i;
        hbd_pkg::RegBank3:    bank_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective tap count 1..N
  logic [hbd_pkg::TapW-1:0] n_eff;
  always_comb begin
    n_eff = tap_q;
    if (tap_q == '0) n_eff = hbd_pkg::TapW'(1);
    else if (tap_q > hbd_pkg::TapW'(N)) n_eff = hbd_pkg::TapW'(N);
  end

  hbd_pkg::state_e state_q, state_d;
  logic phase_q, phase_d;
  logic [CntW:0] cnt_q, cnt_d;
  logic out_v_q, out_v_d;
  hbd_pkg::samp_t oi_q, oq_q;

  logic shift_even, load_odd, rot, mclear, men, fin;
  logic in_acc;

  hbd_pkg::iq_t even_c [N];
  hbd_pkg::iq_t odd_c  [N];
  hbd_pkg::iq_t newv;
  assign newv.i = in_s.data_i;
  assign newv.q = in_s.data_q;

  // cell 0 is the chain head; rotation moves cell k+1 into k so cell 0 shows index cnt
  for (genvar g = 0; g < N; g++) begin : g_cell
    hbd_pkg::iq_t ein, oin, onew;
    if (g == 0) begin : g_head
      assign ein  = rot ? even_c[1] : newv;
      assign oin  = rot ? odd_c[1]  : odd_c[N-1];
      assign onew = newv;
    end else if (g == N-1) begin : g_tail
      assign ein  = rot ? even_c[0] : even_c[g-1];
      assign oin  = rot ? odd_c[0]  : odd_c[g-1];
      assign onew = odd_c[g];
    end else begin : g_mid
      assign ein  = rot ? even_c[g+1] : even_c[g-1];
      assign oin  = rot ? odd_c[g+1]  : odd_c[g-1];
      assign onew = odd_c[g];
    end
    hbd_cell u_cell (
      .clk_i, .rst_ni,
      .shift_even_i (shift_even),
      .load_odd_i   (load_odd && (g == 0)),
      .rot_i        (rot),
      .even_in_i    (ein),
      .odd_in_i     (oin),
      .odd_new_i    (onew),
      .even_o       (even_c[g]),
      .odd_o        (odd_c[g])
    );
  end

  // during the pass, index cnt sits at head; terms latched as they go by
  // accumulator collects c[k]*x for both k and N-1-k, so each visit adds one sample
  logic [CntW:0] nn;
  logic [CntW-1:0] kk;
  logic [CntW-1:0] idx;
  logic odd_n;
  assign nn    = (CntW+1)'(n_eff);
  assign kk    = nn[CntW:1];
  assign odd_n = nn[0];
  assign idx   = cnt_q[CntW-1:0];

  logic signed [15:0] coef;
  logic [CntW-1:0] cidx;
  hbd_pkg::iq_t headv;
  logic use_term;
  logic [CntW:0] mirror;

  always_comb begin
    mirror = nn - 1'b1 - (CntW+1)'(idx);
    use_term = 1'b0;
    cidx = '0;
    coef = '0;
    headv = odd_n ? odd_c[0] : even_c[0];
    if (!odd_n) begin
      if ((CntW+1)'(idx) < (CntW+1)'(kk)) begin
        use_term = 1'b1; cidx = idx;
      end else if ((CntW+1)'(idx) < nn) begin
        use_term = 1'b1; cidx = mirror[CntW-1:0];
      end
      if ((CntW+1)'(idx) == (CntW+1)'(kk) && (CntW+1)'(idx) != nn - 1'b1) begin
        // index K takes both e[K] mirror term (k=N-1-K) handled above; center is odd line
        use_term = 1'b1;
      end
    end else begin
      if (idx >= CntW'(1) && (CntW+1)'(idx) <= (CntW+1)'(kk)) begin
        use_term = 1'b1; cidx = idx - 1'b1;
      end else if ((CntW+1)'(idx) > (CntW+1)'(kk) && (CntW+1)'(idx) < nn) begin
        use_term = 1'b1; cidx = mirror[CntW-1:0];
      end
    end
    if (cidx < CntW'(hbd_pkg::NumCoeffs))
      coef = bank_q[cidx[3:2]][{cidx[1:0], 4'b0000} +: 16];
  end

  // center tap for index K, from the other line
  hbd_pkg::iq_t centv;
  logic use_cent;
  assign centv    = odd_n ? even_c[0] : odd_c[0];
  assign use_cent = ((CntW+1)'(idx) == (CntW+1)'(kk));

  hbd_pkg::acc_t acc_i, acc_q, cen_i_q, cen_q_q;
  logic signed [15:0] zero16;
  assign zero16 = '0;

  hbd_mac u_mac_i (
    .clk_i, .rst_ni, .clear_i (mclear), .en_i (men && use_term),
    .coeff_i (coef), .a_i (headv.i), .b_i (zero16), .acc_o (acc_i)
  );
  hbd_mac u_mac_q (
    .clk_i, .rst_ni, .clear_i (mclear), .en_i (men && use_term),
    .coeff_i (coef), .a_i (headv.q), .b_i (zero16), .acc_o (acc_q)
  );

  always_ff @(posedge clk_i) begin
    if (mclear) begin
      cen_i_q <= '0;
      cen_q_q <= '0;
    end else if (men && use_cent) begin
      cen_i_q <= hbd_pkg::AccW'(centv.i) <<< 14;
      cen_q_q <= hbd_pkg::AccW'(centv.q) <<< 14;
    end
  end

  function automatic hbd_pkg::samp_t rnd_sat(hbd_pkg::acc_t a);
    hbd_pkg::acc_t r;
    r = (a + hbd_pkg::AccW'(16384)) >>> 15;
    if (r > hbd_pkg::AccW'(32767)) return 16'sh7fff;
    if (r < -hbd_pkg::AccW'(32768)) return 16'sh8000;
    return r[15:0];
  endfunction

  assign in_acc   = in_s.valid && in_s.ready;
  assign in_s.ready = (state_q == hbd_pkg::StIdle) && !(phase_q && out_v_q);

  always_comb begin
    state_d = state_q; phase_d = phase_q; cnt_d = cnt_q;
    shift_even = 1'b0; load_odd = 1'b0; rot = 1'b0;
    mclear = 1'b0; men = 1'b0; fin = 1'b0;
    unique case (state_q)
      hbd_pkg::StIdle: begin
        if (in_acc) begin
          if (!phase_q) begin
            shift_even = 1'b1; phase_d = 1'b1;
          end else begin
            load_odd = 1'b1; phase_d = 1'b0; mclear = 1'b1;
            cnt_d = '0; state_d = hbd_pkg::StRun;
          end
        end
      end
      hbd_pkg::StRun: begin
        men = 1'b1; rot = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (CntW+1)'(N-1)) state_d = hbd_pkg::StOut;
      end
      hbd_pkg::StOut: begin
        fin = 1'b1; state_d = hbd_pkg::StIdle;
      end
      default: state_d = hbd_pkg::StIdle;
    endcase
  end

  assign out_v_d = fin ? 1'b1 : (out_s.ready ? 1'b0 : out_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbd_pkg::StIdle; phase_q <= 1'b0; cnt_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; cnt_q <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      oi_q <= rnd_sat(acc_i + cen_i_q);
      oq_q <= rnd_sat(acc_q + cen_q_q);
    end
  end

  assign out_s.valid  = out_v_q;
  assign out_s.data_i = oi_q;
  assign out_s.data_q = oq_q;
endmodule
